FILE: rtl/fat_cluster_table_engine_core_defines.svh
// ----------------------------------------------------------------------------
// FAT cluster table engine assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FAT_CLUSTER_TABLE_ENGINE_CORE_DEFINES_SVH
`define FAT_CLUSTER_TABLE_ENGINE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCTE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fcte_pkg.sv
// ----------------------------------------------------------------------------
// FAT cluster table engine package
// Types, codes and helpers shared by the front end, back end and top level.
// ----------------------------------------------------------------------------
package fcte_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 4096;
    localparam int INDEX_W               = 12;
    localparam int VALUE_W               = 32;
    localparam int HINT_W                = 13;
    localparam int COUNT_W               = 13;
    localparam int QUEUE_DEPTH           = 2;
    localparam int CFG_INDEX_W           = 1;
    localparam int CFG_DATA_W            = 13;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;
    localparam logic [1:0] OP_FREE  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_FAT_TYPE      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLUSTER_COUNT = 1'd1;

    localparam logic [VALUE_W-1:0] EOC_MARK = 32'h0fff_ffff;
    localparam logic [VALUE_W-1:0] MASK16   = 32'h0000_ffff;
    localparam logic [VALUE_W-1:0] ALL_ONES = 32'hffff_ffff;

    localparam logic               FAT_TYPE_RESET      = 1'b1;
    localparam logic [COUNT_W-1:0] CLUSTER_COUNT_RESET = 13'd4096;

    typedef struct packed {
        logic [1:0]         operation;
        logic [INDEX_W-1:0] entry_index;
        logic [VALUE_W-1:0] entry_value;
        logic [INDEX_W-1:0] previous_cluster;
        logic               first_of_chain;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic [VALUE_W-1:0] result_value;
    } out_item_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [INDEX_W-1:0] entry_index;
        logic [VALUE_W-1:0] entry_value;
        logic [INDEX_W-1:0] previous_cluster;
        logic               index_ok;
        logic               link;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    typedef struct packed {
        logic               fat32;
        logic [COUNT_W-1:0] cluster_count;
    } cfg_t;

    function automatic logic [VALUE_W-1:0] entry_view(input logic [VALUE_W-1:0] v,
                                                      input logic fat32);
        return fat32 ? v : (v & MASK16);
    endfunction

endpackage

FILE: rtl/fat_cluster_table_engine_core.sv
// ----------------------------------------------------------------------------
// FAT cluster table engine
// File allocation table with read, set, allocate and free requests.
//
//   Channel   Direction  Handshake            Payload
//   in        input      in_valid / in_stall  in_data (in_item_t)
//   out       output     out_valid/out_stall  out_data (out_item_t)
//   cfg       input      cfg_write            cfg_index, cfg_data
//
// A set writes the table directly, a read or a free waits on one table read,
// and an allocation scans the entries from the search hint at one table read
// per cycle, then marks the end and any link; with nothing to scan it fails.
// After reset the table is cleared one entry per cycle; while it clears, in_stall
// is high and configuration writes are taken.
// A two-entry request queue keeps accepting while a result waits on out_stall.
// ----------------------------------------------------------------------------
module fat_cluster_table_engine_core #(
    parameter int TABLE_ENTRIES = fcte_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  fcte_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output fcte_pkg::out_item_t                 out_data,
    input  logic                                cfg_write,
    input  logic [fcte_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fcte_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fcte_pkg::*;

    cfg_t        cfg_reg;
    queue_head_t head;
    logic        pop;
    logic        clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fat32         <= FAT_TYPE_RESET;
            cfg_reg.cluster_count <= CLUSTER_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FAT_TYPE:      cfg_reg.fat32         <= cfg_data[0];
                REG_CLUSTER_COUNT: cfg_reg.cluster_count <= COUNT_W'(cfg_data);
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    fcte_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .clearing (clearing),
        .pop      (pop),
        .head     (head)
    );

    fcte_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .pop       (pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: rtl/fcte_front.sv
// ----------------------------------------------------------------------------
// FAT cluster table engine front end
// Accepts requests, checks their indexes against the table size and holds
// them in a short command queue for the back end.
// ----------------------------------------------------------------------------
`include "fat_cluster_table_engine_core_defines.svh"

module fcte_front #(
    parameter int TABLE_ENTRIES = fcte_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  fcte_pkg::in_item_t    in_data,
    input  logic                  clearing,
    input  logic                  pop,
    output fcte_pkg::queue_head_t head
);
    import fcte_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             q_store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    cmd_t             new_cmd;
    logic             prev_ok;

    always_comb
    begin
        prev_ok              = 32'(in_data.previous_cluster) < 32'(TABLE_ENTRIES);
        new_cmd.operation    = in_data.operation;
        new_cmd.entry_index  = in_data.entry_index;
        new_cmd.entry_value  = in_data.entry_value;
        new_cmd.previous_cluster = in_data.previous_cluster;
        new_cmd.index_ok     = 32'(in_data.entry_index) < 32'(TABLE_ENTRIES);
        new_cmd.link         = !in_data.first_of_chain && prev_ok;
    end

    assign in_stall   = clearing || (count_reg == FULL_COUNT);
    assign push       = in_valid && !in_stall;
    assign head.valid = (count_reg != '0);
    assign head.cmd   = q_store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_store_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    `FCTE_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= FULL_COUNT, "queue count overflow")
    `FCTE_ASSERT_SAME(a_pop_nonempty, pop, count_reg != '0, "pop from empty queue")
    `FCTE_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + 1'b1,
                      "queue count did not grow on push")

endmodule

FILE: rtl/fcte_back.sv
// ----------------------------------------------------------------------------
// FAT cluster table engine back end
// Holds the allocation table memory, clears it after reset, executes the
// queued commands and registers each result for the output channel.
// ----------------------------------------------------------------------------
`include "fat_cluster_table_engine_core_defines.svh"

module fcte_back #(
    parameter int TABLE_ENTRIES = fcte_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fcte_pkg::cfg_t        cfg,
    input  fcte_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  clearing,
    output logic                  out_valid,
    input  logic                  out_stall,
    output fcte_pkg::out_item_t   out_data
);
    import fcte_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int HINT_MAX = (2 ** HINT_W) - 1;
    localparam logic [HINT_W-1:0] LIMIT_CAP =
        HINT_W'((TABLE_ENTRIES > HINT_MAX) ? HINT_MAX : TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

    localparam logic [2:0] ST_CLEAR     = 3'd0;
    localparam logic [2:0] ST_IDLE      = 3'd1;
    localparam logic [2:0] ST_RD_WAIT   = 3'd2;
    localparam logic [2:0] ST_FREE_WAIT = 3'd3;
    localparam logic [2:0] ST_SCAN      = 3'd4;
    localparam logic [2:0] ST_EOC       = 3'd5;
    localparam logic [2:0] ST_LINK      = 3'd6;

    logic [VALUE_W-1:0] mem [TABLE_ENTRIES];
    logic [VALUE_W-1:0] mem_rdata_reg;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [VALUE_W-1:0] mem_wdata;

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    cmd_t               cmd_reg, cmd_next;
    logic [HINT_W-1:0]  hint_reg, hint_next;
    logic [HINT_W-1:0]  scan_ptr_reg, scan_ptr_next;
    logic [HINT_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [HINT_W-1:0]  found_reg, found_next;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic               out_ready;
    logic               load_out;
    out_item_t          load_data;
    logic [HINT_W-1:0]  limit;
    logic [VALUE_W-1:0] rd_view;

    assign out_ready = !out_valid_reg || !out_stall;
    assign limit     = (cfg.cluster_count < LIMIT_CAP) ? cfg.cluster_count : LIMIT_CAP;
    assign rd_view   = entry_view(mem_rdata_reg, cfg.fat32);
    assign clearing  = (state_reg == ST_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cmd_next      = cmd_reg;
        hint_next     = hint_reg;
        scan_ptr_next = scan_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_pend_next  = 1'b0;
        found_next    = found_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        pop           = 1'b0;
        load_out      = 1'b0;
        load_data     = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid && out_ready)
                begin
                    pop      = 1'b1;
                    cmd_next = head.cmd;
                    unique case (head.cmd.operation)
                        OP_READ:
                        begin
                            if (head.cmd.index_ok)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(head.cmd.entry_index);
                                state_next = ST_RD_WAIT;
                            end
                            else
                            begin
                                load_out               = 1'b1;
                                load_data.result_value = ALL_ONES;
                            end
                        end
                        OP_SET:
                        begin
                            mem_we    = head.cmd.index_ok;
                            mem_waddr = AW'(head.cmd.entry_index);
                            mem_wdata = entry_view(head.cmd.entry_value, cfg.fat32);
                            load_out  = 1'b1;
                        end
                        OP_ALLOC:
                        begin
                            scan_ptr_next = hint_reg;
                            state_next    = ST_SCAN;
                        end
                        OP_FREE:
                        begin
                            if (head.cmd.index_ok)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(head.cmd.entry_index);
                                state_next = ST_FREE_WAIT;
                            end
                            else
                            begin
                                load_out = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                load_out               = 1'b1;
                load_data.result_value = rd_view;
                state_next             = ST_IDLE;
            end
            ST_FREE_WAIT:
            begin
                mem_we                 = 1'b1;
                mem_waddr              = AW'(cmd_reg.entry_index);
                load_out               = 1'b1;
                load_data.result_value = rd_view;
                state_next             = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (rd_pend_reg && (rd_view == '0))
                begin
                    found_next = rd_ptr_reg;
                    state_next = ST_EOC;
                end
                else if (scan_ptr_reg < limit)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = AW'(scan_ptr_reg);
                    rd_ptr_next   = scan_ptr_reg;
                    rd_pend_next  = 1'b1;
                    scan_ptr_next = scan_ptr_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    load_out         = 1'b1;
                    load_data.status = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_EOC:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(found_reg);
                mem_wdata = entry_view(EOC_MARK, cfg.fat32);
                hint_next = found_reg;
                if (cmd_reg.link)
                begin
                    state_next = ST_LINK;
                end
                else
                begin
                    load_out               = 1'b1;
                    load_data.result_value = VALUE_W'(found_reg);
                    state_next             = ST_IDLE;
                end
            end
            ST_LINK:
            begin
                mem_we                 = 1'b1;
                mem_waddr              = AW'(cmd_reg.previous_cluster);
                mem_wdata              = entry_view(VALUE_W'(found_reg), cfg.fat32);
                load_out               = 1'b1;
                load_data.result_value = VALUE_W'(found_reg);
                state_next             = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            hint_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            hint_reg     <= hint_next;
            rd_pend_reg  <= rd_pend_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        scan_ptr_reg <= scan_ptr_next;
        rd_ptr_reg   <= rd_ptr_next;
        found_reg    <= found_next;
        if (load_out)
        begin
            out_data_reg <= load_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    `FCTE_ASSERT_SAME(a_pop_needs_slot, pop, out_ready && state_reg == ST_IDLE,
                      "command taken while the result slot is busy")
    `FCTE_ASSERT_SAME(a_write_states, mem_we,
                      state_reg == ST_CLEAR || state_reg == ST_IDLE ||
                      state_reg == ST_FREE_WAIT || state_reg == ST_EOC ||
                      state_reg == ST_LINK,
                      "table written outside a writing state")
    `FCTE_ASSERT_NEXT(a_hint_in_limit, state_reg == ST_EOC, hint_reg < limit,
                      "search hint moved past the scan limit")

endmodule
